// ===== sv/gcs_pkg.sv =====
package gcs_pkg;

	localparam int WORD_W  = 64;
	localparam int ADDR_W  = 11;
	localparam int HEAD_W  = 10;
	localparam int BND_W   = 11;
	localparam int LIVE_W  = 14;
	localparam int BW_W    = 9;
	localparam int DS_W    = 10;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 1;

	localparam int CHUNK_WORDS_DEF = 1024;
	localparam int WORD_BYTES_DEF  = 8;

	localparam logic [BW_W-1:0]   BW_RESET = BW_W'(4);
	localparam logic [DS_W-1:0]   DS_RESET = DS_W'(64);
	localparam logic [LIVE_W-1:0] LIVE_MAX = LIVE_W'(16383);

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BOUND = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_SWEEP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 1'd1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
		logic              wptr;
		logic              wmark;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] rdata;
		logic              rptr;
		logic              rmark;
		logic [HEAD_W-1:0] list_head;
		logic [BND_W-1:0]  boundary;
		logic [LIVE_W-1:0] live_bytes;
		logic              any_mark;
	} rsp_t;

	// one heap entry: the word with its pointer and mark bits
	typedef struct packed {
		logic              ptr;
		logic              mark;
		logic [WORD_W-1:0] word;
	} entry_t;

endpackage

// ===== sv/gcs_req_if.sv =====
interface gcs_req_if;
	logic          valid;
	logic          ready;
	gcs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gcs_rsp_if.sv =====
interface gcs_rsp_if;
	logic          valid;
	logic          ready;
	gcs_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gcs_mem.sv =====
module gcs_mem #(
	parameter int DEPTH = gcs_pkg::CHUNK_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  gcs_pkg::entry_t                 wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output gcs_pkg::entry_t                 rdata
);

	gcs_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/gc_chunk_sweep.sv =====
// Sweep engine for one heap chunk of a mark-sweep collector.
// Commands arrive as beats on req: load a word with its pointer and mark bits,
// set the bump boundary, read a word back, or sweep. Each command yields one
// rsp beat carrying the read word (zero unless a read), the free list head,
// the boundary, the live byte count and whether any mark bit is set.
// One command is in work at a time. A load writes the new entry back and then
// posts its result, a read waits on the memory before posting, and a boundary
// set or an address past the chunk goes straight to the result; req is ready
// again the cycle after the result register is loaded. A sweep tests blocks
// at the top, zeroes the words above the new boundary, walks the blocks below
// it and zeroes the words of each freed block, then runs a mark clearing pass
// over the chunk.
// After reset the block sweeps the entry memory once, clearing pointer and
// mark bits, and req.ready stays low throughout that pass. Config
// writes are taken at any time, including during that pass.
// The result sits in an output register; a new command is accepted while it
// waits. A stalled receiver only holds the next result back: the engine
// waits with it finished until the register frees up.
module gc_chunk_sweep #(
	parameter int CHUNK_WORDS = gcs_pkg::CHUNK_WORDS_DEF,
	parameter int WORD_BYTES  = gcs_pkg::WORD_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gcs_pkg::CFG_W-1:0]        cfg_data,
	gcs_req_if.sink                          req,
	gcs_rsp_if.source                        rsp
);

	localparam int AW  = $clog2(CHUNK_WORDS);
	// position width: holds chunk indices, data start plus block size
	localparam int VW  = ((AW + 1 > gcs_pkg::BND_W) ? AW + 1 : gcs_pkg::BND_W) + 1;
	localparam int LSW = gcs_pkg::LIVE_W + 2;

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_LD_WR  = 4'd2;
	localparam logic [3:0] ST_RD_WT  = 4'd3;
	localparam logic [3:0] ST_FIN    = 4'd4;
	localparam logic [3:0] ST_R_CHK  = 4'd5;
	localparam logic [3:0] ST_R_WT   = 4'd6;
	localparam logic [3:0] ST_ZERO   = 4'd7;
	localparam logic [3:0] ST_W_CHK  = 4'd8;
	localparam logic [3:0] ST_W_WT   = 4'd9;
	localparam logic [3:0] ST_W_ZERO = 4'd10;
	localparam logic [3:0] ST_CLR    = 4'd11;

	localparam logic [VW-1:0] CHUNK_V = VW'(CHUNK_WORDS);
	localparam logic [VW-1:0] BND_RST = (VW'(gcs_pkg::DS_RESET) > CHUNK_V) ?
		CHUNK_V : VW'(gcs_pkg::DS_RESET);

	logic [3:0]                   state_q;
	logic [gcs_pkg::BW_W-1:0]     bw_q;
	logic [gcs_pkg::DS_W-1:0]     ds_q;
	logic [VW-1:0]                bnd_q, fi_q, orig_q, b_q, idx_q;
	logic [AW-1:0]                head_q;
	logic [gcs_pkg::LIVE_W-1:0]   live_q;
	logic [AW:0]                  mcnt_q;
	logic [AW-1:0]                ld_addr_q;
	gcs_pkg::entry_t              ld_q, res_q;
	logic                         rsp_valid_q;
	gcs_pkg::rsp_t                rsp_q;

	logic [VW-1:0]  wpb_v, ds_v, lim_v, blk_end_v, addr_v, rd_v, wr_v;
	logic [LSW-1:0] bytes_v, live_sum_v;
	logic           req_fire, in_range, rsp_free;
	logic           mem_we, mem_re;
	gcs_pkg::entry_t mem_wd, mem_rd;

	// zero block size acts as one word, zero data start as one
	assign wpb_v     = (bw_q == '0) ? VW'(1) : VW'(bw_q);
	assign ds_v      = (ds_q == '0) ? VW'(1) : VW'(ds_q);
	assign lim_v     = ds_v + wpb_v;
	assign blk_end_v = b_q + wpb_v;
	assign addr_v    = VW'(req.data.addr);
	assign in_range  = addr_v < CHUNK_V;
	assign bytes_v   = LSW'(wpb_v) * LSW'(WORD_BYTES);
	assign live_sum_v = LSW'(live_q) + bytes_v;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	gcs_mem #(.DEPTH(CHUNK_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_v[AW-1:0]),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (rd_v[AW-1:0]),
		.rdata (mem_rd)
	);

	// memory port steering per state
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		wr_v   = '0;
		rd_v   = '0;
		mem_wd = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				wr_v   = idx_q;
			end
			ST_IDLE: begin
				if (req_fire && in_range &&
				    (req.data.cmd == gcs_pkg::CMD_LOAD ||
				     req.data.cmd == gcs_pkg::CMD_READ)) begin
					mem_re = 1'b1;
					rd_v   = addr_v;
				end
			end
			ST_LD_WR: begin
				mem_we = 1'b1;
				wr_v   = VW'(ld_addr_q);
				mem_wd = ld_q;
			end
			ST_R_CHK: begin
				mem_re = fi_q >= lim_v;
				rd_v   = fi_q - wpb_v;
			end
			ST_ZERO: begin
				mem_we = idx_q < orig_q;
				wr_v   = idx_q;
			end
			ST_W_CHK: begin
				mem_re = b_q >= lim_v;
				rd_v   = b_q - wpb_v;
			end
			ST_W_WT: begin
				// free block: link its first word to the old head
				mem_we      = !mem_rd.mark;
				wr_v        = b_q;
				mem_wd.word = gcs_pkg::WORD_W'(head_q);
			end
			ST_W_ZERO: begin
				mem_we = idx_q < blk_end_v;
				wr_v   = idx_q;
			end
			ST_CLR: begin
				// read ahead one entry, write back the previous one unmarked
				mem_re      = idx_q < CHUNK_V;
				rd_v        = idx_q;
				mem_we      = idx_q != '0;
				wr_v        = idx_q - VW'(1);
				mem_wd.ptr  = mem_rd.ptr;
				mem_wd.word = mem_rd.word;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			bw_q        <= gcs_pkg::BW_RESET;
			ds_q        <= gcs_pkg::DS_RESET;
			bnd_q       <= BND_RST;
			head_q      <= '0;
			live_q      <= '0;
			mcnt_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gcs_pkg::REG_BLOCK_WORDS: bw_q <= cfg_data[gcs_pkg::BW_W-1:0];
					gcs_pkg::REG_DATA_START:  ds_q <= cfg_data[gcs_pkg::DS_W-1:0];
					default: begin
					end
				endcase
			end
			// raise valid when a result is posted, drop it once taken
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + VW'(1);
					if (idx_q == CHUNK_V - VW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						res_q     <= '0;
						ld_addr_q <= addr_v[AW-1:0];
						ld_q.ptr  <= req.data.wptr;
						ld_q.mark <= req.data.wmark;
						ld_q.word <= req.data.wdata;
						unique case (req.data.cmd)
							gcs_pkg::CMD_LOAD:  state_q <= in_range ? ST_LD_WR : ST_FIN;
							gcs_pkg::CMD_READ:  state_q <= in_range ? ST_RD_WT : ST_FIN;
							gcs_pkg::CMD_BOUND: begin
								bnd_q   <= (addr_v > CHUNK_V) ? CHUNK_V : addr_v;
								state_q <= ST_FIN;
							end
							gcs_pkg::CMD_SWEEP: begin
								fi_q    <= bnd_q;
								orig_q  <= bnd_q;
								state_q <= ST_R_CHK;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_LD_WR: begin
					// keep the count of set marks current
					if (mem_rd.mark && !ld_q.mark) begin
						mcnt_q <= mcnt_q - (AW+1)'(1);
					end else if (!mem_rd.mark && ld_q.mark) begin
						mcnt_q <= mcnt_q + (AW+1)'(1);
					end
					state_q <= ST_FIN;
				end
				ST_RD_WT: begin
					res_q   <= mem_rd;
					state_q <= ST_FIN;
				end
				ST_R_CHK: begin
					if (fi_q >= lim_v) begin
						state_q <= ST_R_WT;
					end else begin
						idx_q   <= fi_q;
						state_q <= ST_ZERO;
					end
				end
				ST_R_WT: begin
					// stop pulling back at the first marked block
					if (mem_rd.mark) begin
						idx_q   <= fi_q;
						state_q <= ST_ZERO;
					end else begin
						fi_q    <= fi_q - wpb_v;
						state_q <= ST_R_CHK;
					end
				end
				ST_ZERO: begin
					if (idx_q < orig_q) begin
						idx_q <= idx_q + VW'(1);
					end else begin
						bnd_q   <= fi_q;
						b_q     <= fi_q;
						live_q  <= '0;
						head_q  <= '0;
						state_q <= ST_W_CHK;
					end
				end
				ST_W_CHK: begin
					if (b_q >= lim_v) begin
						b_q     <= b_q - wpb_v;
						state_q <= ST_W_WT;
					end else begin
						idx_q   <= '0;
						state_q <= ST_CLR;
					end
				end
				ST_W_WT: begin
					if (mem_rd.mark) begin
						live_q  <= (live_sum_v > LSW'(gcs_pkg::LIVE_MAX)) ?
							gcs_pkg::LIVE_MAX : live_sum_v[gcs_pkg::LIVE_W-1:0];
						state_q <= ST_W_CHK;
					end else begin
						head_q  <= b_q[AW-1:0];
						idx_q   <= b_q + VW'(1);
						state_q <= ST_W_ZERO;
					end
				end
				ST_W_ZERO: begin
					if (idx_q < blk_end_v) begin
						idx_q <= idx_q + VW'(1);
					end else begin
						state_q <= ST_W_CHK;
					end
				end
				ST_CLR: begin
					if (idx_q == CHUNK_V) begin
						mcnt_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + VW'(1);
					end
				end
				ST_FIN: begin
					// hold the finished result until the output register frees up
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && rsp_free) begin
			rsp_q.rdata      <= res_q.word;
			rsp_q.rptr       <= res_q.ptr;
			rsp_q.rmark      <= res_q.mark;
			rsp_q.list_head  <= gcs_pkg::HEAD_W'(head_q);
			rsp_q.boundary   <= bnd_q[gcs_pkg::BND_W-1:0];
			rsp_q.live_bytes <= live_q;
			rsp_q.any_mark   <= mcnt_q != '0;
		end
	end

endmodule

// ===== dv/gcs_sweep_checker.sv =====
`timescale 1ns / 100ps

module gcs_sweep_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcs_pkg::CFG_W-1:0]     cfg_data,
	gcs_req_if                            req,
	gcs_rsp_if                            rsp,
	output int                            fails,
	output int                            pending
);
	import gcs_pkg::*;

	localparam int NWORDS = CHUNK_WORDS_DEF;

	logic [WORD_W-1:0] heap [NWORDS];
	bit                ptr_bits [NWORDS];
	bit                mark_bits [NWORDS];
	int                head;
	int                bound;
	int                live;
	int                blk_words;
	int                dstart;
	rsp_t              due_q [$];

	// Reclaim trailing blocks, thread free blocks high to low, clear marks.
	function automatic void sweep_chunk();
		int wpb;
		int ds;
		int orig;
		int fi;
		int b;
		wpb = (blk_words == 0) ? 1 : blk_words;
		ds = (dstart == 0) ? 1 : dstart;
		orig = bound;
		fi = orig;
		while (fi >= ds + wpb && !mark_bits[fi - wpb])
			fi -= wpb;
		for (int i = fi; i < orig; i++) begin
			heap[i] = '0;
			ptr_bits[i] = 0;
		end
		bound = fi;
		live = 0;
		head = 0;
		b = fi;
		while (b >= ds + wpb) begin
			b -= wpb;
			if (mark_bits[b]) begin
				live += wpb * WORD_BYTES_DEF;
				if (live > int'(LIVE_MAX))
					live = int'(LIVE_MAX);
			end else begin
				heap[b] = WORD_W'(head);
				ptr_bits[b] = 0;
				head = b;
				for (int i = 1; i < wpb; i++) begin
					heap[b + i] = '0;
					ptr_bits[b + i] = 0;
				end
			end
		end
		for (int i = 0; i < NWORDS; i++)
			mark_bits[i] = 0;
	endfunction

	function automatic rsp_t apply_command(req_t r);
		rsp_t o;
		bit   marked;
		o = '0;
		marked = 0;
		case (r.cmd)
			CMD_LOAD: begin
				if (r.addr < NWORDS) begin
					heap[r.addr] = r.wdata;
					ptr_bits[r.addr] = r.wptr;
					mark_bits[r.addr] = r.wmark;
				end
			end
			CMD_BOUND: bound = (r.addr > NWORDS) ? NWORDS : int'(r.addr);
			CMD_READ: begin
				if (r.addr < NWORDS) begin
					o.rdata = heap[r.addr];
					o.rptr = ptr_bits[r.addr];
					o.rmark = mark_bits[r.addr];
				end
			end
			default: sweep_chunk();
		endcase
		for (int i = 0; i < NWORDS; i++)
			if (mark_bits[i])
				marked = 1;
		o.list_head = HEAD_W'(head);
		o.boundary = BND_W'(bound);
		o.live_bytes = LIVE_W'(live);
		o.any_mark = marked;
		return o;
	endfunction

	function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
			logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < NWORDS; i++) begin
				heap[i] = '0;
				ptr_bits[i] = 0;
				mark_bits[i] = 0;
			end
			head = 0;
			bound = int'(DS_RESET);
			live = 0;
			blk_words = int'(BW_RESET);
			dstart = int'(DS_RESET);
			due_q.delete();
			fails = fails;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BLOCK_WORDS)
					blk_words = int'(cfg_data[BW_W-1:0]);
				else if (cfg_index == REG_DATA_START)
					dstart = int'(cfg_data[DS_W-1:0]);
			end
			if (req.valid && req.ready)
				due_q.push_back(apply_command(req.data));
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					$error("result beat with no command outstanding");
					fails++;
				end else begin
					e = due_q.pop_front();
					check_field("rdata", e.rdata, rsp.data.rdata);
					check_field("rptr", e.rptr, rsp.data.rptr);
					check_field("rmark", e.rmark, rsp.data.rmark);
					check_field("list_head", e.list_head, rsp.data.list_head);
					check_field("boundary", e.boundary, rsp.data.boundary);
					check_field("live_bytes", e.live_bytes, rsp.data.live_bytes);
					check_field("any_mark", e.any_mark, rsp.data.any_mark);
				end
			end
		end
		pending = due_q.size();
	end

	initial begin
		fails = 0;
		pending = 0;
	end
endmodule

// ===== dv/tb_gc_chunk_sweep.sv =====
`timescale 1ns / 100ps

module tb_gc_chunk_sweep;
	import gcs_pkg::*;

	localparam int NWORDS = CHUNK_WORDS_DEF;
	localparam int CYCLE_LIMIT = 20000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fails;
	int                   pending;
	bit                   idle_on;
	int                   sent;
	int                   blk_words;
	int                   dstart;
	// addresses loaded so far; reads of the chunk stay on these
	bit                   loaded [NWORDS];
	int                   loaded_q [$];

	gcs_req_if req_ch ();
	gcs_rsp_if rsp_ch ();

	gc_chunk_sweep dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	gcs_sweep_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: stall in short random bursts while idling is on.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready = 0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				rsp_ch.ready = 1;
			end
		end
	end

	// Drive one command beat and hold it until accepted; returns at a falling edge.
	task automatic send_cmd(logic [1:0] cmd, int addr, logic [WORD_W-1:0] wdata,
			bit wptr, bit wmark);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_ch.valid = 1;
		req_ch.data.cmd = cmd;
		req_ch.data.addr = ADDR_W'(addr);
		req_ch.data.wdata = wdata;
		req_ch.data.wptr = wptr;
		req_ch.data.wmark = wmark;
		// ready is settled between edges; the beat goes at the next rising edge
		while (!req_ch.ready)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		sent++;
		if (cmd == CMD_LOAD && addr < NWORDS && !loaded[addr]) begin
			loaded[addr] = 1;
			loaded_q.push_back(addr);
		end
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic load_word(int addr, bit wmark);
		send_cmd(CMD_LOAD, addr, rand_word(), 1'($urandom), wmark);
	endtask

	// Read a loaded word, or now and then an address past the chunk.
	task automatic read_some();
		int a;
		if (loaded_q.size() == 0 || $urandom_range(0, 7) == 0)
			a = $urandom_range(NWORDS, 2047);
		else
			a = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
		send_cmd(CMD_READ, a, rand_word(), 1'($urandom), 1'($urandom));
	endtask

	// Drain all results, let the engine settle, then write both registers.
	task automatic set_regs(int bw, int ds);
		req_ch.valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1;
		cfg_index = REG_BLOCK_WORDS;
		cfg_data = CFG_W'(bw);
		@(negedge clk);
		cfg_index = REG_DATA_START;
		cfg_data = CFG_W'(ds);
		@(negedge clk);
		cfg_we = 0;
		blk_words = bw;
		dstart = ds;
	endtask

	// A well-formed round: place the boundary a few blocks up, load blocks
	// with random marks, sweep, then read back.
	task automatic sweep_round();
		int wpb;
		int ds;
		int base;
		int nb;
		int top;
		wpb = (blk_words == 0) ? 1 : blk_words;
		ds = (dstart == 0) ? 1 : dstart;
		base = ds + wpb * $urandom_range(0, 3);
		nb = $urandom_range(1, 8);
		while (nb > 0 && base + nb * wpb > NWORDS)
			nb--;
		if (nb == 0)
			base = ds;
		// a ragged boundary sometimes, to exercise alignment
		top = base + nb * wpb + (($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 0);
		if (top > NWORDS)
			top = NWORDS;
		send_cmd(CMD_BOUND, top, rand_word(), 1'($urandom), 1'($urandom));
		for (int k = 0; k < nb; k++) begin
			load_word(base + k * wpb, 1'($urandom));
			if (wpb > 1 && $urandom_range(0, 2) == 0)
				load_word(base + k * wpb + $urandom_range(1, wpb - 1),
					$urandom_range(0, 5) == 0);
		end
		send_cmd(CMD_SWEEP, 0, rand_word(), 1'($urandom), 1'($urandom));
		repeat ($urandom_range(1, 4)) read_some();
	endtask

	// Noise: any command with random fields; sweeps are kept rare.
	task automatic noise_beat();
		int c;
		c = $urandom_range(0, 9);
		if (c < 4)
			send_cmd(CMD_LOAD, $urandom_range(0, 2047), rand_word(),
				1'($urandom), 1'($urandom));
		else if (c < 6)
			send_cmd(CMD_BOUND, $urandom_range(0, 2047), rand_word(),
				1'($urandom), 1'($urandom));
		else if (c < 9)
			read_some();
		else
			send_cmd(CMD_SWEEP, $urandom_range(0, 2047), rand_word(),
				1'($urandom), 1'($urandom));
	endtask

	initial begin
		int bw_set [10];
		int ds_set [10];
		int quota;
		bw_set = '{4, 1, 0, 256, 511, 2, 3, 8, 1, 4};
		ds_set = '{64, 1, 0, 1, 1023, 100, 1000, 0, 1023, 64};
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_BLOCK_WORDS;
		cfg_data = '0;
		req_ch.valid = 0;
		req_ch.data = '0;
		idle_on = 1;
		sent = 0;
		blk_words = int'(BW_RESET);
		dstart = int'(DS_RESET);
		repeat (3) @(negedge clk);
		arst_n = 1;

		// Directed: field extremes, out-of-chunk addresses, boundary saturation,
		// sweep with the boundary under data start, then a short marked sweep.
		send_cmd(CMD_LOAD, 0, '1, 1, 1);
		send_cmd(CMD_LOAD, NWORDS - 1, '0, 0, 0);
		send_cmd(CMD_LOAD, NWORDS, '1, 1, 1);
		send_cmd(CMD_LOAD, 2047, '1, 1, 1);
		send_cmd(CMD_READ, 0, '0, 0, 0);
		send_cmd(CMD_READ, NWORDS - 1, '1, 1, 1);
		send_cmd(CMD_READ, NWORDS, '0, 0, 0);
		send_cmd(CMD_READ, 2047, '0, 0, 0);
		send_cmd(CMD_BOUND, 2047, '0, 0, 0);
		send_cmd(CMD_BOUND, 0, '0, 0, 0);
		send_cmd(CMD_SWEEP, 0, '0, 0, 0);
		send_cmd(CMD_BOUND, 80, '0, 0, 0);
		send_cmd(CMD_LOAD, 64, 64'h5555_aaaa_0f0f_f0f0, 1, 1);
		send_cmd(CMD_LOAD, 68, 64'h1234_5678_9abc_def0, 1, 0);
		send_cmd(CMD_LOAD, 72, 64'h0, 0, 1);
		send_cmd(CMD_LOAD, 76, '1, 1, 0);
		send_cmd(CMD_SWEEP, 0, '0, 0, 0);
		send_cmd(CMD_READ, 64, '0, 0, 0);
		send_cmd(CMD_READ, 68, '0, 0, 0);
		send_cmd(CMD_READ, 76, '0, 0, 0);
		send_cmd(CMD_SWEEP, 0, '0, 0, 0);

		// Random phases, one register setting each; the last runs without idling.
		foreach (bw_set[p]) begin
			set_regs(bw_set[p], ds_set[p]);
			if (p == $size(bw_set) - 1)
				idle_on = 0;
			quota = sent + 150;
			while (sent < quota) begin
				if ($urandom_range(0, 9) < 6)
					sweep_round();
				else
					noise_beat();
			end
		end

		req_ch.valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
